@@ rtl/core/srcu_pkg.sv @@
// Shared constants, types and key helper for the series rank coalesce unit.
package srcu_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 32;
	localparam int SAMPLE_W   = 32;
	localparam int CODE_W     = 6;
	localparam int DCNT_W     = 7;
	localparam int ADDR_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

	typedef logic [VALUE_BITS-1:0] key_t;

	// result of the shared comparator
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_LATCH = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// low VALUE_BITS bits with the sign bit flipped: unsigned order = signed order
	function automatic key_t to_key(input logic [SAMPLE_W-1:0] v);
		key_t k;
		k = v[VALUE_BITS-1:0];
		k[VALUE_BITS-1] = ~k[VALUE_BITS-1];
		return k;
	endfunction

endpackage

@@ rtl/core/srcu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module srcu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/srcu_cmp.sv @@
// Shared key comparator: less-than and equal on order-preserving keys.
module srcu_cmp (
	input  srcu_pkg::key_t a,
	input  srcu_pkg::key_t b,
	output srcu_pkg::cmp_t res
);

	import srcu_pkg::*;

	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
	end

endmodule

@@ rtl/core/series_rank_coalesce_unit.sv @@
// Top level of the series rank coalesce unit: sequencer, key store and shared comparator.
//
// Coordinate compression of a series of signed values. Requests are taken one per cycle
// while the unit is loading; each stores its value (up to MAX_ITEMS of them; further values
// are dropped and the status bit is set on every result of the series). The request marked
// last_item ends the series, after which in_stall stays high until all results have gone.
// The unit then makes two passes over the stored values through one shared read address
// (key store and first-occurrence flags side by side) and one comparator: a dedup pass
// (each item checked against all earlier ones) and a rank pass (each item counted against
// all first occurrences), one comparison per cycle. Results come in arrival order: code is
// the rank among distinct values (0 = smallest), distinct_count the number of distinct
// values, and last_code marks the final one. The state is cleared when that final result
// is taken.
module series_rank_coalesce_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [srcu_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                            last_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [srcu_pkg::CODE_W-1:0]     code,
	output logic [srcu_pkg::DCNT_W-1:0]     distinct_count,
	output logic                            last_code,
	output logic                            status
);

	import srcu_pkg::*;

	// sequencer state
	state_t                state_q;
	logic                  phase_q;     // 0: dedup pass, 1: rank pass
	logic [CNT_W-1:0]      n_q;         // stored items
	logic                  ovf_q;       // series truncated
	logic [ADDR_W-1:0]     i_q;         // item under test
	logic [CNT_W-1:0]      j_q;         // scan read pointer
	logic                  dup_q;
	logic [ADDR_W-1:0]     rank_q;
	logic [CNT_W-1:0]      dcnt_q;      // distinct values found
	logic                  out_valid_q;

	// scan pipeline (registered RAM read)
	logic                  rv_s1;

	// payload registers
	key_t                  ref_q;
	logic [CODE_W-1:0]     code_q;
	logic                  last_code_q;

	// datapath
	logic                  in_acc;
	logic                  out_acc;
	logic                  room;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_raddr;
	key_t                  mem_rdata;
	logic                  first_we;
	logic                  first_rdata; // stored item is first occurrence of its value
	cmp_t                  cmp;
	logic [CNT_W-1:0]      limit;
	logic                  scan_end;
	logic                  hit_dup;
	logic                  hit_lt;
	logic                  is_first;
	logic                  i_last;

	assign in_acc  = in_valid & ~in_stall;
	assign out_acc = out_valid_q & ~out_stall;
	assign room    = (n_q < CNT_W'(MAX_ITEMS));
	assign mem_we  = in_acc & room;

	assign mem_raddr = (state_q == ST_SCAN) ? j_q[ADDR_W-1:0] : i_q;

	// dedup pass looks at earlier items only, rank pass at all of them
	assign limit    = phase_q ? n_q : CNT_W'(i_q);
	assign scan_end = (j_q == limit);
	assign hit_dup  = rv_s1 & cmp.eq;
	assign hit_lt   = rv_s1 & phase_q & cmp.lt & first_rdata;
	assign is_first = ~(dup_q | hit_dup);
	assign i_last   = ((CNT_W'(i_q) + CNT_W'(1)) == n_q);
	assign first_we = (state_q == ST_SCAN) & scan_end & ~phase_q;

	srcu_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (n_q[ADDR_W-1:0]),
		.wdata (to_key(sample_value)),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// first-occurrence flags, written by the dedup pass, read beside the keys
	srcu_ram #(
		.WIDTH (1),
		.DEPTH (MAX_ITEMS)
	) u_first (
		.clk   (clk),
		.we    (first_we),
		.waddr (i_q),
		.wdata (is_first),
		.raddr (mem_raddr),
		.rdata (first_rdata)
	);

	// compares stored key j against the item under test
	srcu_cmp u_cmp (
		.a   (mem_rdata),
		.b   (ref_q),
		.res (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			phase_q     <= 1'b0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			dup_q       <= 1'b0;
			rank_q      <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			rv_s1       <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							n_q <= n_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							state_q <= ST_FETCH;
							phase_q <= 1'b0;
							i_q     <= '0;
							dcnt_q  <= '0;
						end
					end
				end
				ST_FETCH: begin
					j_q     <= '0;
					dup_q   <= 1'b0;
					rank_q  <= '0;
					rv_s1   <= 1'b0;
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rv_s1 <= ~scan_end;
					if (!scan_end) begin
						j_q <= j_q + CNT_W'(1);
					end
					if (hit_dup) begin
						dup_q <= 1'b1;
					end
					if (hit_lt) begin
						rank_q <= rank_q + ADDR_W'(1);
					end
					if (scan_end) begin
						if (!phase_q) begin
							if (is_first) begin
								dcnt_q <= dcnt_q + CNT_W'(1);
							end
							if (i_last) begin
								phase_q <= 1'b1;
								i_q     <= '0;
							end else begin
								i_q <= i_q + ADDR_W'(1);
							end
							state_q <= ST_FETCH;
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_code_q) begin
							state_q <= ST_LOAD;
							phase_q <= 1'b0;
							n_q     <= '0;
							ovf_q   <= 1'b0;
							dcnt_q  <= '0;
						end else begin
							i_q     <= i_q + ADDR_W'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LATCH) begin
			ref_q <= mem_rdata;
		end
		if ((state_q == ST_SCAN) && scan_end && phase_q) begin
			code_q      <= CODE_W'(rank_q + ADDR_W'(hit_lt));
			last_code_q <= i_last;
		end
	end

	assign in_stall       = (state_q != ST_LOAD);
	assign out_valid      = out_valid_q;
	assign code           = code_q;
	assign distinct_count = DCNT_W'(dcnt_q);
	assign last_code      = last_code_q;
	assign status         = ovf_q;

`ifndef SYNTHESIS
	a_rank_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (DCNT_W'(code) < distinct_count))
		else $error("rank not below distinct count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (dcnt_q != '0 && dcnt_q <= n_q))
		else $error("distinct count out of range");

	a_series_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_code) |=>
		(state_q == ST_LOAD && n_q == '0 && !ovf_q))
		else $error("series state not cleared after final result");

	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("scan compare outside scan");
`endif

endmodule

@@ tb/srcu_rank_check.sv @@
// Rank checker for the series rank coalesce unit: watches both channels and scores results.
module srcu_rank_check (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [srcu_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                 last_item,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [srcu_pkg::CODE_W-1:0]          code,
	input  logic [srcu_pkg::DCNT_W-1:0]          distinct_count,
	input  logic                                 last_code,
	input  logic                                 status,
	output int                                   mismatches,
	output int                                   expected_left
);
	timeunit 1ns;
	timeprecision 1ps;

	import srcu_pkg::*;

	typedef logic signed [VALUE_BITS-1:0] sval_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [DCNT_W-1:0] dcnt;
		logic              last;
		logic              status;
	} rank_result_t;

	sval_t        series_vals[$];
	bit           truncated;
	rank_result_t awaited_q[$];

	// series closed: rank every stored value against the distinct set
	function automatic void queue_ranks();
		sval_t        distinct_vals[$];
		rank_result_t r;
		int           below;
		bit           seen;
		foreach (series_vals[i]) begin
			seen = 1'b0;
			foreach (distinct_vals[j])
				if (distinct_vals[j] == series_vals[i])
					seen = 1'b1;
			if (!seen)
				distinct_vals.push_back(series_vals[i]);
		end
		foreach (series_vals[i]) begin
			below = 0;
			foreach (distinct_vals[j])
				if (distinct_vals[j] < series_vals[i])
					below++;
			r.code   = CODE_W'(below);
			r.dcnt   = DCNT_W'(distinct_vals.size());
			r.last   = (i == series_vals.size() - 1);
			r.status = truncated;
			awaited_q.push_back(r);
		end
		series_vals.delete();
		truncated = 1'b0;
	endfunction

	function automatic void score_result();
		rank_result_t want;
		rank_result_t got;
		got = '{code, distinct_count, last_code, status};
		if (awaited_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"unexpected result: code %0d distinct_count %0d",
					" last_code %0b status %0b"},
					got.code, got.dcnt, got.last, got.status);
		end else begin
			want = awaited_q.pop_front();
			if (got != want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: code %0d/%0d distinct_count %0d/%0d",
						" last_code %0b/%0b status %0b/%0b (exp/got)"},
						want.code, got.code, want.dcnt, got.dcnt,
						want.last, got.last, want.status, got.status);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_vals.delete();
			awaited_q.delete();
			truncated  = 1'b0;
			mismatches = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (series_vals.size() < MAX_ITEMS)
					series_vals.push_back(sample_value[VALUE_BITS-1:0]);
				else
					truncated = 1'b1;
				if (last_item)
					queue_ranks();
			end
			if (out_valid && !out_stall)
				score_result();
		end
		expected_left <= awaited_q.size();
	end

endmodule

@@ tb/testbench.sv @@
// Top of the series rank coalesce testbench: clock, reset, request stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import srcu_pkg::*;

	// cycles with no handshake on either side before the run is abandoned
	localparam int IDLE_LIMIT  = 40000;
	// long output hold-off: long enough for the next series to back up at the input
	localparam int HOLD_CYCLES = 300;

	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;

	// how the values of one series are drawn
	typedef enum logic [1:0] {
		VAL_WIDE,   // any 32-bit value, nearly always distinct
		VAL_NARROW, // -4..4, lots of repeats
		VAL_EDGE,   // extremes and their neighbours
		VAL_MIXED   // wide and narrow interleaved
	} val_mix_t;

	logic                       clk;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_value = '0;
	logic                       last_item    = 1'b0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic [CODE_W-1:0]          code;
	logic [DCNT_W-1:0]          distinct_count;
	logic                       last_code;
	logic                       status;

	int mismatches;
	int expected_left;
	int sent_count  = 0;
	int idle_cycles = 0;
	bit calm        = 1'b0; // set for the closing stretch: no idling on either side
	bit held_off    = 1'b0;

	series_rank_coalesce_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_value   (sample_value),
		.last_item      (last_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code           (code),
		.distinct_count (distinct_count),
		.last_code      (last_code),
		.status         (status)
	);

	srcu_rank_check u_rank_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_value   (sample_value),
		.last_item      (last_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code           (code),
		.distinct_count (distinct_count),
		.last_code      (last_code),
		.status         (status),
		.mismatches     (mismatches),
		.expected_left  (expected_left)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one request and hold it until taken. Called on a rising edge; returns on
	// the edge that accepted it (or after a short idle burst), so the next request can
	// go out on that same edge without valid dropping in between.
	task automatic offer_sample(input logic signed [SAMPLE_W-1:0] v, input logic fin);
		in_valid     <= 1'b1;
		sample_value <= v;
		last_item    <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic signed [SAMPLE_W-1:0] draw_value(input val_mix_t mix);
		case (mix)
			VAL_WIDE:   return $urandom;
			VAL_NARROW: return $urandom_range(0, 8) - 4;
			VAL_EDGE: begin
				case ($urandom_range(0, 5))
					0:       return S_MIN;
					1:       return S_MAX;
					2:       return '0;
					3:       return -1;
					4:       return S_MIN + 1;
					default: return S_MAX - 1;
				endcase
			end
			default:    return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8) - 4;
		endcase
	endfunction

	// one series of random content; the request at the end carries last_item
	task automatic send_series(input int len, input val_mix_t mix);
		for (int i = 0; i < len; i++)
			offer_sample(draw_value(mix), i == len - 1);
	endtask

	// mostly short series; now and then a long one near the store size that may
	// fill the store or run past it
	function automatic int series_length();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(60, 72);
		return $urandom_range(1, 12);
	endfunction

	// Stimulus
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, a repeated extreme, zero and minus one in one series
		offer_sample(S_MIN, 1'b0);
		offer_sample(S_MAX, 1'b0);
		offer_sample('0, 1'b0);
		offer_sample(-1, 1'b0);
		offer_sample(S_MAX, 1'b0);
		offer_sample(1, 1'b0);
		offer_sample(S_MIN, 1'b1);
		// shortest series: a lone request marked last
		offer_sample('0, 1'b1);
		// all values equal: one distinct value, every code zero
		repeat (4) offer_sample(-7, 1'b0);
		offer_sample(-7, 1'b1);
		// strictly descending: codes come out reversed
		offer_sample(100, 1'b0);
		offer_sample(10, 1'b0);
		offer_sample('0, 1'b0);
		offer_sample(-10, 1'b0);
		offer_sample(-100, 1'b1);
		// alternating bit patterns, one repeated
		offer_sample(32'sh5555_5555, 1'b0);
		offer_sample(32'shAAAA_AAAA, 1'b0);
		offer_sample(32'sh5555_5555, 1'b1);

		// store exactly full with 64 wide values (nearly always distinct), then a series that overruns it:
		// the extra requests, the last one among them, are dropped and status is set
		send_series(MAX_ITEMS, VAL_WIDE);
		send_series(MAX_ITEMS + 6, VAL_NARROW);
		send_series(MAX_ITEMS + 1, VAL_EDGE);

		while (sent_count < 440)
			send_series(series_length(), val_mix_t'($urandom_range(0, 3)));

		// closing stretch at full rate on both sides
		calm = 1'b1;
		while (sent_count < 500)
			send_series($urandom_range(1, 8), VAL_MIXED);
		in_valid <= 1'b0;

		// let the checker register the final series before waiting on it
		@(posedge clk);
		wait (expected_left == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_left == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Output side: one long hold-off on the first result (the next series backs up
	// behind it and the unit stalls its input), then random stall bursts.
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && out_valid) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				held_off = 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Watchdog: counts cycles without a handshake on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

@@ sim.f @@
rtl/core/srcu_pkg.sv
rtl/core/srcu_ram.sv
rtl/core/srcu_cmp.sv
rtl/core/series_rank_coalesce_unit.sv
tb/srcu_rank_check.sv
tb/testbench.sv
